// File: rtl/hth_pkg.sv
// hth_pkg: shared types, constants and codes of the heater thermostat
`default_nettype none

package hth_pkg;

    // sensor conversion
    localparam int ADC_BITS            = 10;
    localparam int SAMPLES_PER_READING = 3;
    localparam int MV_W                = 12;
    localparam int PROD_W              = ADC_BITS + MV_W;
    localparam logic [MV_W-1:0] FULL_SCALE_MV = 12'd3300;
    localparam logic [MV_W-1:0] OFFSET_MV     = 12'd500;

    // field and state widths
    localparam int TEMP_W  = 11;
    localparam int TOL_W   = 8;
    localparam int SUM_W   = 12;
    localparam int AVG_W   = 10;
    localparam int CNT_W   = 2;
    localparam int HOLD_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
    localparam logic [AVG_W-1:0]  AVG_MAX = {AVG_W{1'b1}};
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 2**SUM_W
    localparam logic [SUM_W-1:0] RECIP3       = 12'd2731;
    localparam int               RECIP3_SHIFT = 13;

    // item kinds
    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_TICK     = 2'd1;
    localparam logic [1:0] KIND_SETPOINT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MV     = 3'd4;

    // configuration reset values
    localparam logic [TEMP_W-1:0] RST_DEFAULT_SP = 11'd0;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE  = 8'd20;
    localparam logic [TEMP_W-1:0] RST_TEMP_LIMIT = 11'd1000;
    localparam logic [MV_W-1:0]   RST_MIN_MV     = 12'd200;
    localparam logic [MV_W-1:0]   RST_MAX_MV     = 12'd3000;

    typedef enum logic [2:0] {
        ST_COLLECT     = 3'd0,
        ST_DECISION    = 3'd1,
        ST_BAD_VOLT    = 3'd2,
        ST_RANGE_FAULT = 3'd3,
        ST_NO_VALID    = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic conv;
        logic sample;
        logic div;
        logic decide;
        logic misc;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_is_sample;
        logic need_div;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/hth_in_if.sv
// hth_in_if: input item channel of the heater thermostat
`default_nettype none

interface hth_in_if
    import hth_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [ADC_BITS-1:0]   adc_code;
    logic [TEMP_W-1:0]     new_setpoint;
    logic [HOLD_W-1:0]     hold_seconds;

    modport source (output valid, output kind, output adc_code, output new_setpoint,
                    output hold_seconds, input ready);
    modport sink   (input valid, input kind, input adc_code, input new_setpoint,
                    input hold_seconds, output ready);
endinterface

`default_nettype wire

// File: rtl/hth_out_if.sv
// hth_out_if: result channel of the heater thermostat
`default_nettype none

interface hth_out_if
    import hth_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              heater_on;
    logic [AVG_W-1:0]  average_temp;
    logic [2:0]        status;
    logic              group_done;
    logic [TEMP_W-1:0] setpoint_now;
    logic              override_active;

    modport source (output valid, output heater_on, output average_temp, output status,
                    output group_done, output setpoint_now, output override_active,
                    input ready);
    modport sink   (input valid, input heater_on, input average_temp, input status,
                    input group_done, input setpoint_now, input override_active,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/hth_ctrl.sv
// hth_ctrl: sequencing state machine and handshake control of the thermostat
`default_nettype none

module hth_ctrl
    import hth_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SAMPLE,
        S_DIV,
        S_DECIDE,
        S_MISC,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    ready_next  = 1'b0;
                    state_next  = sts.in_is_sample ? S_CONV : S_MISC;
                end
            end
            S_CONV:
            begin
                cmd.conv   = 1'b1;
                state_next = S_SAMPLE;
            end
            S_SAMPLE:
            begin
                cmd.sample = 1'b1;
                state_next = sts.need_div ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_MISC:
            begin
                cmd.misc   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // result register is free or its transaction completes now
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    ready_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = ready_reg;
    assign out_valid = out_valid_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == S_IDLE))
        else $error("input ready out of step with idle state");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && ready_reg)
        else $error("emitted result not presented or input not reopened");

    a_div_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div |=> state_reg == S_DECIDE)
        else $error("division not followed by decision");

endmodule

`default_nettype wire

// File: rtl/hth_dp.sv
// hth_dp: configuration registers, sample averaging, hysteresis and override timer
`default_nettype none

module hth_dp
    import hth_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input item payload
    input  wire logic [1:0]            kind,
    input  wire logic [ADC_BITS-1:0]   adc_code,
    input  wire logic [TEMP_W-1:0]     new_setpoint,
    input  wire logic [HOLD_W-1:0]     hold_seconds,
    // control
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    // result payload
    output logic                       heater_on,
    output logic [AVG_W-1:0]           average_temp,
    output logic [2:0]                 status,
    output logic                       group_done,
    output logic [TEMP_W-1:0]          setpoint_now,
    output logic                       override_active
);

    // configuration
    logic [TEMP_W-1:0] default_sp_reg;
    logic [TOL_W-1:0]  tolerance_reg;
    logic [TEMP_W-1:0] temp_limit_reg;
    logic [MV_W-1:0]   min_mv_reg;
    logic [MV_W-1:0]   max_mv_reg;

    // captured item
    logic [1:0]          kind_reg;
    logic [ADC_BITS-1:0] code_reg;
    logic [TEMP_W-1:0]   new_sp_reg;
    logic [HOLD_W-1:0]   hold_reg;

    // thermostat state
    logic              heater_reg;
    logic [CNT_W-1:0]  attempt_count_reg;
    logic [CNT_W-1:0]  valid_count_reg;
    logic [SUM_W-1:0]  temp_sum_reg;
    logic [AVG_W-1:0]  last_average_reg;
    logic [TEMP_W-1:0] setpoint_reg;
    logic [HOLD_W-1:0] override_len_reg;
    logic [HOLD_W-1:0] elapsed_reg;

    // per-item working registers
    logic [MV_W-1:0]   mv_reg;
    logic [SUM_W-1:0]  div_num_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [SUM_W-1:0]  quot_reg;
    status_t           status_reg;
    logic              done_reg;

    // result register
    logic              res_heater_reg;
    logic [AVG_W-1:0]  res_average_reg;
    status_t           res_status_reg;
    logic              res_done_reg;
    logic [TEMP_W-1:0] res_setpoint_reg;
    logic              res_override_reg;

    // conversion
    logic [PROD_W-1:0] mv_prod;

    // sample classification
    logic              bad_volt;
    logic              range_fault;
    logic [MV_W-1:0]   temp_val;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_new;
    logic [CNT_W-1:0]  attempt_new;
    logic [CNT_W-1:0]  valid_new;
    logic              group_end;

    // division and decision
    logic [2*SUM_W-1:0] recip_prod;
    logic [SUM_W:0]     avg_plus_tol;
    logic [SUM_W:0]     sp_plus_tol;

    // timer
    logic [HOLD_W-1:0] elapsed_inc;

    assign mv_prod = PROD_W'(code_reg) * PROD_W'(FULL_SCALE_MV);

    always_comb
    begin
        bad_volt    = (mv_reg < min_mv_reg) || (mv_reg > max_mv_reg);
        temp_val    = mv_reg - OFFSET_MV;
        range_fault = (mv_reg < OFFSET_MV) || (temp_val > MV_W'(temp_limit_reg));
        sum_add     = {1'b0, temp_sum_reg} + {1'b0, temp_val};
        sum_new     = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        attempt_new = attempt_count_reg + 1'b1;
        valid_new   = (bad_volt || range_fault) ? valid_count_reg : valid_count_reg + 1'b1;
        group_end   = (!bad_volt && range_fault) ? 1'b0
                    : (32'(attempt_new) >= SAMPLES_PER_READING);
    end

    assign sts.in_is_sample = (kind == KIND_SAMPLE);
    assign sts.need_div     = group_end && (valid_new != '0);

    assign recip_prod   = (2*SUM_W)'(div_num_reg) * (2*SUM_W)'(RECIP3);
    assign avg_plus_tol = {1'b0, quot_reg} + (SUM_W+1)'(tolerance_reg);
    assign sp_plus_tol  = (SUM_W+1)'(setpoint_reg) + (SUM_W+1)'(tolerance_reg);
    assign elapsed_inc  = (elapsed_reg != HOLD_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_sp_reg <= RST_DEFAULT_SP;
            tolerance_reg  <= RST_TOLERANCE;
            temp_limit_reg <= RST_TEMP_LIMIT;
            min_mv_reg     <= RST_MIN_MV;
            max_mv_reg     <= RST_MAX_MV;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEFAULT_SP: default_sp_reg <= cfg_data[TEMP_W-1:0];
                REG_TOLERANCE:  tolerance_reg  <= cfg_data[TOL_W-1:0];
                REG_TEMP_LIMIT: temp_limit_reg <= cfg_data[TEMP_W-1:0];
                REG_MIN_MV:     min_mv_reg     <= cfg_data[MV_W-1:0];
                REG_MAX_MV:     max_mv_reg     <= cfg_data[MV_W-1:0];
                default:        ;
            endcase
        end
    end

    // thermostat state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg        <= 1'b0;
            attempt_count_reg <= '0;
            valid_count_reg   <= '0;
            temp_sum_reg      <= '0;
            last_average_reg  <= '0;
            setpoint_reg      <= RST_DEFAULT_SP;
            override_len_reg  <= '0;
            elapsed_reg       <= '0;
            status_reg        <= ST_COLLECT;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                status_reg <= ST_COLLECT;
                done_reg   <= 1'b0;
            end

            if (cmd.sample)
            begin
                if (bad_volt)
                begin
                    // a group end reports the group result instead
                    if (!group_end)
                    begin
                        status_reg <= ST_BAD_VOLT;
                    end
                end
                else if (range_fault)
                begin
                    heater_reg <= 1'b0;
                    status_reg <= ST_RANGE_FAULT;
                    done_reg   <= 1'b1;
                end

                if (range_fault && !bad_volt)
                begin
                    attempt_count_reg <= '0;
                    valid_count_reg   <= '0;
                    temp_sum_reg      <= '0;
                end
                else if (group_end)
                begin
                    done_reg          <= 1'b1;
                    attempt_count_reg <= '0;
                    valid_count_reg   <= '0;
                    temp_sum_reg      <= '0;
                    if (valid_new == '0)
                    begin
                        heater_reg <= 1'b0;
                        status_reg <= ST_NO_VALID;
                    end
                    else
                    begin
                        status_reg <= ST_DECISION;
                    end
                end
                else
                begin
                    attempt_count_reg <= attempt_new;
                    valid_count_reg   <= valid_new;
                    if (!bad_volt)
                    begin
                        temp_sum_reg <= sum_new;
                    end
                end
            end

            if (cmd.decide)
            begin
                last_average_reg <= (quot_reg > SUM_W'(AVG_MAX)) ? AVG_MAX
                                                                 : quot_reg[AVG_W-1:0];
                // hysteresis: on below the band if the setpoint is under the limit, off above it, hold inside
                if (avg_plus_tol < (SUM_W+1)'(setpoint_reg))
                begin
                    if (setpoint_reg < temp_limit_reg)
                    begin
                        heater_reg <= 1'b1;
                    end
                end
                else if ({1'b0, quot_reg} > sp_plus_tol)
                begin
                    heater_reg <= 1'b0;
                end
            end

            if (cmd.misc)
            begin
                case (kind_reg)
                    KIND_TICK:
                    begin
                        if (override_len_reg != '0)
                        begin
                            if (elapsed_inc >= override_len_reg)
                            begin
                                setpoint_reg     <= default_sp_reg;
                                override_len_reg <= '0;
                                elapsed_reg      <= '0;
                            end
                            else
                            begin
                                elapsed_reg <= elapsed_inc;
                            end
                        end
                    end
                    KIND_SETPOINT:
                    begin
                        setpoint_reg     <= new_sp_reg;
                        override_len_reg <= hold_reg;
                        elapsed_reg      <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            code_reg   <= adc_code;
            new_sp_reg <= new_setpoint;
            hold_reg   <= hold_seconds;
        end
        if (cmd.conv)
        begin
            mv_reg <= mv_prod[PROD_W-1:ADC_BITS];
        end
        if (cmd.sample)
        begin
            div_num_reg <= bad_volt ? temp_sum_reg : sum_new;
            div_cnt_reg <= valid_new;
        end
        if (cmd.div)
        begin
            case (div_cnt_reg)
                2'd1:    quot_reg <= div_num_reg;
                2'd2:    quot_reg <= div_num_reg >> 1;
                default: quot_reg <= SUM_W'(recip_prod >> RECIP3_SHIFT);
            endcase
        end
        if (cmd.emit)
        begin
            res_heater_reg   <= heater_reg;
            res_average_reg  <= last_average_reg;
            res_status_reg   <= status_reg;
            res_done_reg     <= done_reg;
            res_setpoint_reg <= setpoint_reg;
            res_override_reg <= (override_len_reg != '0);
        end
    end

    assign heater_on       = res_heater_reg;
    assign average_temp    = res_average_reg;
    assign status          = res_status_reg;
    assign group_done      = res_done_reg;
    assign setpoint_now    = res_setpoint_reg;
    assign override_active = res_override_reg;

    a_valid_le_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        valid_count_reg <= attempt_count_reg)
        else $error("more valid samples than attempts in group");

    a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid_count_reg == '0 |-> temp_sum_reg == '0)
        else $error("nonzero sum with no valid samples");

    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        override_len_reg == '0 |-> elapsed_reg == '0)
        else $error("override timer running without an override");

endmodule

`default_nettype wire

// File: rtl/heater_thermostat_hysteresis.sv
// heater_thermostat_hysteresis: top level of the bang-bang heater thermostat
//
//  channel   | dir | transaction payload
//  ----------+-----+-------------------------------------------------------------
//  item      | in  | kind, adc_code, new_setpoint, hold_seconds
//  result    | out | heater_on, average_temp, status, group_done, setpoint_now,
//            |     | override_active
//  cfg_*     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// one item at a time: a sample that does not close a group runs the conversion,
// sample and emit steps, one that closes a group with valid samples adds the
// reciprocal multiply and decision; ticks and setpoint changes run misc and emit.
// the result register lets the next item be accepted while a result waits.
// a stalled result channel holds the sequencer in its emit step.
// after reset the setpoint equals the default_setpoint reset value, heater off.
`default_nettype none

module heater_thermostat_hysteresis
    import hth_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    hth_in_if.sink                     item,
    hth_out_if.source                  result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;
    logic out_valid;
    logic heater_on;
    logic [AVG_W-1:0]  average_temp;
    logic [2:0]        status;
    logic              group_done;
    logic [TEMP_W-1:0] setpoint_now;
    logic              override_active;

    hth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hth_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (item.kind),
        .adc_code        (item.adc_code),
        .new_setpoint    (item.new_setpoint),
        .hold_seconds    (item.hold_seconds),
        .cmd             (cmd),
        .sts             (sts),
        .heater_on       (heater_on),
        .average_temp    (average_temp),
        .status          (status),
        .group_done      (group_done),
        .setpoint_now    (setpoint_now),
        .override_active (override_active)
    );

    assign item.ready             = in_ready;
    assign result.valid           = out_valid;
    assign result.heater_on       = heater_on;
    assign result.average_temp    = average_temp;
    assign result.status          = status;
    assign result.group_done      = group_done;
    assign result.setpoint_now    = setpoint_now;
    assign result.override_active = override_active;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for the heater thermostat with hysteresis
`timescale 1ns / 100ps

module tb_top;
    import hth_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ADC_BITS-1:0] adc_code;
        logic [TEMP_W-1:0]   new_setpoint;
        logic [HOLD_W-1:0]   hold_seconds;
    } thermo_item_t;

    typedef struct packed {
        logic              heater_on;
        logic [AVG_W-1:0]  average_temp;
        status_t           status;
        logic              group_done;
        logic [TEMP_W-1:0] setpoint_now;
        logic              override_active;
    } thermo_reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hth_in_if item_if ();
    hth_out_if result_if ();

    heater_thermostat_hysteresis dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if.sink),
        .result    (result_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // register copies
    logic [TEMP_W-1:0] default_sp_reg;
    logic [TOL_W-1:0]  tolerance_reg;
    logic [TEMP_W-1:0] temp_limit_reg;
    logic [MV_W-1:0]   min_mv_reg;
    logic [MV_W-1:0]   max_mv_reg;

    // thermostat state copy
    logic              heater_lvl;
    logic [CNT_W-1:0]  attempts;
    logic [CNT_W-1:0]  valid_samples;
    logic [SUM_W-1:0]  temp_total;
    logic [AVG_W-1:0]  group_avg;
    logic [TEMP_W-1:0] active_sp;
    logic [HOLD_W-1:0] hold_len;
    logic [HOLD_W-1:0] hold_elapsed;

    thermo_item_t    item_backlog[$];
    thermo_reading_t readings_due[$];
    int err_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;
    int sp_center = 0;

    function automatic thermo_reading_t predict_thermostat(input thermo_item_t it);
        thermo_reading_t r;
        int mv;
        int t;
        int s;
        int avg;
        logic done;
        status_t st;
        done = 1'b0;
        st = ST_COLLECT;
        if (it.kind == KIND_SAMPLE) begin
            mv = (int'(it.adc_code) * 3300) >> ADC_BITS;
            attempts = attempts + 1'b1;
            if (mv < int'(min_mv_reg) || mv > int'(max_mv_reg)) begin
                st = ST_BAD_VOLT;
            end
            else begin
                t = mv - 500;
                if (t < 0 || t > int'(temp_limit_reg)) begin
                    heater_lvl = 1'b0;
                    attempts = '0;
                    valid_samples = '0;
                    temp_total = '0;
                    st = ST_RANGE_FAULT;
                    done = 1'b1;
                end
                else begin
                    s = int'(temp_total) + t;
                    temp_total = (s > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
                    valid_samples = valid_samples + 1'b1;
                end
            end
            if (!done && int'(attempts) >= SAMPLES_PER_READING) begin
                done = 1'b1;
                if (valid_samples == 0) begin
                    heater_lvl = 1'b0;
                    st = ST_NO_VALID;
                end
                else begin
                    avg = int'(temp_total) / int'(valid_samples);
                    group_avg = (avg > int'(AVG_MAX)) ? AVG_MAX : AVG_W'(avg);
                    if (avg < int'(active_sp) - int'(tolerance_reg)) begin
                        // no heating when the setpoint sits at or above the limit
                        if (active_sp < temp_limit_reg)
                            heater_lvl = 1'b1;
                    end
                    else if (avg > int'(active_sp) + int'(tolerance_reg)) begin
                        heater_lvl = 1'b0;
                    end
                    st = ST_DECISION;
                end
                attempts = '0;
                valid_samples = '0;
                temp_total = '0;
            end
        end
        else if (it.kind == KIND_TICK) begin
            if (hold_len != 0) begin
                if (hold_elapsed != HOLD_MAX)
                    hold_elapsed = hold_elapsed + 1'b1;
                if (hold_elapsed >= hold_len) begin
                    active_sp = default_sp_reg;
                    hold_len = '0;
                    hold_elapsed = '0;
                end
            end
        end
        else if (it.kind == KIND_SETPOINT) begin
            active_sp = it.new_setpoint;
            hold_len = it.hold_seconds;
            hold_elapsed = '0;
        end
        r.heater_on = heater_lvl;
        r.average_temp = group_avg;
        r.status = st;
        r.group_done = done;
        r.setpoint_now = active_sp;
        r.override_active = (hold_len != 0);
        return r;
    endfunction

    function automatic thermo_item_t random_item();
        thermo_item_t it;
        int r;
        int t;
        int span;
        it.kind = KIND_SAMPLE;
        it.adc_code = ADC_BITS'($urandom);
        it.new_setpoint = TEMP_W'($urandom_range(0, 1500));
        it.hold_seconds = HOLD_W'($urandom);
        r = $urandom_range(99);
        if (r < 70) begin
            r = $urandom_range(99);
            if (r < 75) begin
                if (r < 45) begin
                    // aim around the setpoint so the band edges get crossed
                    span = int'(tolerance_reg) + 40;
                    t = sp_center - span + int'($urandom_range(0, 2 * span));
                end
                else begin
                    t = $urandom_range(0, int'(temp_limit_reg) + 60);
                end
                if (t < 0)
                    t = 0;
                t = ((t + 500) * 1024 + 3299) / 3300;
                it.adc_code = (t > 1023) ? {ADC_BITS{1'b1}} : ADC_BITS'(t);
            end
        end
        else if (r < 88) begin
            it.kind = KIND_TICK;
        end
        else if (r < 97) begin
            it.kind = KIND_SETPOINT;
            if ($urandom_range(99) < 60)
                it.new_setpoint = TEMP_W'($urandom_range(0, int'(temp_limit_reg)));
            r = $urandom_range(99);
            if (r < 40)
                it.hold_seconds = HOLD_W'($urandom_range(1, 5));
            else if (r < 60)
                it.hold_seconds = '0;
            else if (r < 90)
                it.hold_seconds = HOLD_W'($urandom_range(6, 40));
            sp_center = int'(it.new_setpoint);
        end
        else begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // item driver
    always @(posedge clk) begin
        thermo_item_t nxt;
        thermo_item_t cur;
        if (!rst_n) begin
            item_if.valid <= 1'b0;
        end
        else begin
            if (item_if.valid && item_if.ready) begin
                cur.kind = item_if.kind;
                cur.adc_code = item_if.adc_code;
                cur.new_setpoint = item_if.new_setpoint;
                cur.hold_seconds = item_if.hold_seconds;
                readings_due.push_back(predict_thermostat(cur));
            end
            if (!item_if.valid || item_if.ready) begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = item_backlog.pop_front();
                    item_if.valid <= 1'b1;
                    item_if.kind <= nxt.kind;
                    item_if.adc_code <= nxt.adc_code;
                    item_if.new_setpoint <= nxt.new_setpoint;
                    item_if.hold_seconds <= nxt.hold_seconds;
                end
                else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        thermo_reading_t want;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
        end
        else begin
            if (result_if.valid && result_if.ready) begin
                if (readings_due.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_count++;
                end
                else begin
                    want = readings_due.pop_front();
                    check_field("heater_on", want.heater_on, result_if.heater_on);
                    check_field("average_temp", want.average_temp, result_if.average_temp);
                    check_field("status", want.status, result_if.status);
                    check_field("group_done", want.group_done, result_if.group_done);
                    check_field("setpoint_now", want.setpoint_now, result_if.setpoint_now);
                    check_field("override_active", want.override_active,
                                result_if.override_active);
                end
            end
            result_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int dflt, input int tol, input int tmax,
                              input int mv_lo, input int mv_hi);
        write_reg(REG_DEFAULT_SP, dflt);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_TEMP_LIMIT, tmax);
        write_reg(REG_MIN_MV, mv_lo);
        write_reg(REG_MAX_MV, mv_hi);
        default_sp_reg = TEMP_W'(dflt);
        tolerance_reg = TOL_W'(tol);
        temp_limit_reg = TEMP_W'(tmax);
        min_mv_reg = MV_W'(mv_lo);
        max_mv_reg = MV_W'(mv_hi);
        sp_center = int'(active_sp);
    endtask

    task automatic queue_item(input logic [1:0] k, input int code, input int sp,
                              input int hold);
        thermo_item_t it;
        it = random_item();
        it.kind = k;
        if (k == KIND_SAMPLE)
            it.adc_code = ADC_BITS'(code);
        if (k == KIND_SETPOINT) begin
            it.new_setpoint = TEMP_W'(sp);
            it.hold_seconds = HOLD_W'(hold);
        end
        item_backlog.push_back(it);
    endtask

    task automatic run_items(input int count, input int send_pct, input int recv_pct,
                             input bit squeeze);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
        repeat (count) item_backlog.push_back(random_item());
        if (squeeze) begin
            // long receiver hold-off so the block backs up into its input
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (400) @(posedge clk);
                    hold_off <= 1'b0;
                end
            join_none
        end
        while (item_backlog.size() != 0 || item_if.valid || readings_due.size() != 0 ||
               hold_off)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.kind = '0;
        item_if.adc_code = '0;
        item_if.new_setpoint = '0;
        item_if.hold_seconds = '0;
        result_if.ready = 1'b0;

        default_sp_reg = RST_DEFAULT_SP;
        tolerance_reg = RST_TOLERANCE;
        temp_limit_reg = RST_TEMP_LIMIT;
        min_mv_reg = RST_MIN_MV;
        max_mv_reg = RST_MAX_MV;
        heater_lvl = 1'b0;
        attempts = '0;
        valid_samples = '0;
        temp_total = '0;
        group_avg = '0;
        active_sp = RST_DEFAULT_SP;
        hold_len = '0;
        hold_elapsed = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed checks at the reset settings
        queue_item(KIND_UNUSED, 0, 0, 0);
        queue_item(KIND_TICK, 0, 0, 0);
        queue_item(KIND_SETPOINT, 0, 500, 0);
        // out-of-window voltages only: empty group
        queue_item(KIND_SAMPLE, 0, 0, 0);
        queue_item(KIND_SAMPLE, 1023, 0, 0);
        queue_item(KIND_SAMPLE, 62, 0, 0);
        // cold group turns the heater on, warm group turns it off
        repeat (3) queue_item(KIND_SAMPLE, 200, 0, 0);
        repeat (3) queue_item(KIND_SAMPLE, 350, 0, 0);
        // just below zero, then just above the limit mid group
        queue_item(KIND_SAMPLE, 155, 0, 0);
        queue_item(KIND_SAMPLE, 156, 0, 0);
        queue_item(KIND_SAMPLE, 466, 0, 0);
        // one invalid sample in a group, average over two
        queue_item(KIND_SAMPLE, 465, 0, 0);
        queue_item(KIND_SAMPLE, 0, 0, 0);
        queue_item(KIND_SAMPLE, 156, 0, 0);
        // setpoint at the limit blocks heating
        queue_item(KIND_SETPOINT, 0, 1000, 0);
        repeat (3) queue_item(KIND_SAMPLE, 200, 0, 0);
        // timed override expires back to the default
        queue_item(KIND_SETPOINT, 0, 300, 2);
        queue_item(KIND_TICK, 0, 0, 0);
        queue_item(KIND_TICK, 0, 0, 0);
        queue_item(KIND_SETPOINT, 0, 1500, 65535);
        queue_item(KIND_TICK, 0, 0, 0);
        queue_item(KIND_SETPOINT, 0, 0, 1);
        queue_item(KIND_TICK, 0, 0, 0);
        run_items(250, 0, 0, 1'b0);

        set_config(600, 0, 1500, 0, 3300);
        run_items(300, 59, 0, 1'b0);

        set_config(1500, 255, 1500, 200, 3000);
        run_items(300, 0, 59, 1'b0);

        set_config(0, 255, 0, 500, 3300);
        run_items(250, 6, 6, 1'b0);

        set_config(400, 10, 800, 3300, 0);
        run_items(100, 0, 0, 1'b0);

        set_config(700, 30, 1200, 100, 2500);
        run_items(380, 6, 6, 1'b1);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/hth_pkg.sv
rtl/hth_in_if.sv
rtl/hth_out_if.sv
rtl/hth_ctrl.sv
rtl/hth_dp.sv
rtl/heater_thermostat_hysteresis.sv
tb/sv/tb_top.sv
